>>> sv/d2fw_pkg.sv
// Package with the field widths and constants of the double to float word converter.
package d2fw_pkg;
   localparam int unsigned DoubleWidth = 64;
   localparam int unsigned WordWidth   = 48;
   localparam int unsigned MantWidth   = 41;
   localparam int unsigned ExpWidth    = 11;
   localparam int unsigned FracWidth   = 52;
   localparam logic [ExpWidth-1:0] ExpAllOnes = 11'h7FF;
   localparam logic [ExpWidth-1:0] ExpZero    = 11'h000;
   // Biased word exponent is ex - 1022 + 64, that is ex - 958.
   localparam logic signed [12:0] ExpOffset = 13'sd958;
   localparam logic signed [12:0] ExpMaxWord = 13'sd127;
   localparam logic [MantWidth-1:0] HalfOne = 41'h100_0000_0000 >> 1;
   localparam logic [MantWidth-1:0] FullOne = 41'h100_0000_0000;

   // Stage 1 to stage 2 contents.
   typedef struct packed {
      logic                   zero;
      logic                   special;
      logic                   neg;
      logic signed [12:0]     expo;
      logic [MantWidth-1:0]   mag;
   } stage_a_type;

   // Stage 2 to stage 3 contents.
   typedef struct packed {
      logic                   zero;
      logic                   err;
      logic                   neg;
      logic [6:0]             expo;
      logic [MantWidth-1:0]   mag;
   } stage_b_type;
endpackage

>>> sv/double_to_48bit_float_word.sv
// Top level of the pipelined double to 48-bit float word converter.
//
//  Channel  | Ports                              | Direction
//  request  | req_valid, req_stall, req_value_bits | in (stall out)
//  response | rsp_valid, rsp_stall, rsp_float_word, rsp_range_error | out (stall in)
//
// Three register stages: round, normalise and range check, negate and pack.
// One transaction is accepted per cycle while the response side does not stall.
// Reset clears the valid bits of every stage.
// A stall from the response side holds a full stage only when every later stage is full;
// a stage moves when it is empty or the next one moves, so bubbles are squeezed out.
module double_to_48bit_float_word
   import d2fw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DoubleWidth-1:0] req_value_bits,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WordWidth-1:0]   rsp_float_word,
   output logic                   rsp_range_error
);
   logic v1_ff, v2_ff, v3_ff;
   logic mv1, mv2, mv3;
   stage_a_type a_ff, a_in;
   stage_b_type b_ff, b_in;
   logic [WordWidth-1:0] word_ff, word_in;
   logic err_ff, err_in;

   // Stage enables from the back.
   assign mv3 = !v3_ff || !rsp_stall;
   assign mv2 = !v2_ff || mv3;
   assign mv1 = !v1_ff || mv2;
   assign req_stall = !mv1;

   // Stage 1: unpack fields and round the significand to 41 bits.
   always_comb begin
      logic [ExpWidth-1:0] ex;
      logic [FracWidth-1:0] frac;
      logic [FracWidth:0] sig;
      logic [FracWidth+1:0] sum;
      ex   = req_value_bits[62:52];
      frac = req_value_bits[FracWidth-1:0];
      sig  = {1'b1, frac};
      sum  = {1'b0, sig} + 54'h1000;
      a_in.zero    = (ex == ExpZero) && (frac == '0);
      a_in.special = (ex == ExpZero) || (ex == ExpAllOnes);
      a_in.neg     = req_value_bits[63];
      a_in.expo    = $signed({2'b00, ex}) - ExpOffset;
      a_in.mag     = sum[FracWidth+1:13];
   end

   // Stage 2: fix up a positive rounding carry and minus one half, then check range.
   always_comb begin
      logic signed [12:0] e;
      logic [MantWidth-1:0] m;
      e = a_ff.expo;
      m = a_ff.mag;
      if (!a_ff.neg && m >= FullOne) begin
         m = m >> 1;
         e = e + 13'sd1;
      end
      if (a_ff.neg && m == HalfOne) begin
         m = FullOne;
         e = e - 13'sd1;
      end
      b_in.zero = a_ff.zero;
      b_in.neg  = a_ff.neg;
      b_in.err  = !a_ff.zero && (a_ff.special || e < 13'sd1 || e > ExpMaxWord);
      b_in.expo = e[6:0];
      b_in.mag  = m;
   end

   // Stage 3: two's complement and pack; zero or error gives the zero word.
   always_comb begin
      logic [MantWidth-1:0] mant;
      mant    = b_ff.neg ? (~b_ff.mag + 41'd1) : b_ff.mag;
      err_in  = b_ff.err;
      word_in = (b_ff.zero || b_ff.err) ? '0 : {b_ff.expo, mant};
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (mv1) v1_ff <= req_valid;
         if (mv2) v2_ff <= v1_ff;
         if (mv3) v3_ff <= v2_ff;
      end
      if (mv1) a_ff <= a_in;
      if (mv2) b_ff <= b_in;
      if (mv3) begin
         word_ff <= word_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_float_word  = word_ff;
   assign rsp_range_error = err_ff;
endmodule

>>> sv/d2fw_checker.sv
// Port checker for the converter, with its bind statement.
module d2fw_checker
   import d2fw_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WordWidth-1:0] rsp_float_word,
   input logic                 rsp_range_error
);
   // An error result carries the zero word.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_float_word == '0) else $error("error word not zero");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_float_word)) else $error("result changed");

   // No result appears without an earlier request.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid, 3)) else $error("result invented");

   // While the output is free the input is never stalled.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall) else $error("needless stall");
endmodule

bind double_to_48bit_float_word d2fw_checker u_d2fw_checker (.*);

>>> tb/sv/tb_double_to_48bit_float_word.sv
// Testbench for the double to 48-bit float word converter.
`timescale 1ns / 100ps

module tb_double_to_48bit_float_word
   import d2fw_pkg::*;
();

   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic                 range_error;
   } float_result_type;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned DrainCycles = 10;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [DoubleWidth-1:0] req_value_bits;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [WordWidth-1:0]   rsp_float_word;
   logic                   rsp_range_error;

   logic [DoubleWidth-1:0] pending_values[$];
   float_result_type       expected_words[$];
   int unsigned            mismatch_count = 0;
   int unsigned            cycle_count = 0;
   int                     burst_left;
   int                     gap_left;
   bit                     hold_off;
   bit                     stimulus_done;
   bit                     req_taken = 1'b0;

   double_to_48bit_float_word u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_float_word (rsp_float_word),
      .rsp_range_error(rsp_range_error)
   );

   // Predicts the float word for one double bit pattern.
   function automatic float_result_type convert_double(input logic [DoubleWidth-1:0] bits);
      float_result_type     res;
      logic                 neg;
      logic [ExpWidth-1:0]  ex;
      logic [FracWidth-1:0] frac;
      logic [53:0]          sig;
      logic [41:0]          mag;
      int                   e;
      logic [MantWidth-1:0] mant;
      res  = '0;
      neg  = bits[63];
      ex   = bits[62:52];
      frac = bits[51:0];
      if (ex == ExpZero && frac == '0) return res;
      if (ex == ExpZero || ex == ExpAllOnes) begin
         res.range_error = 1'b1;
         return res;
      end
      sig = {2'b01, frac} + 54'd4096;
      mag = {1'b0, sig[53:13]};
      e   = int'(ex) - 1022 + 64;
      if (!neg && mag >= 42'h100_0000_0000) begin
         mag = mag >> 1;
         e++;
      end
      if (neg && mag == 42'h080_0000_0000) begin
         mag = 42'h100_0000_0000;
         e--;
      end
      if (e < 1 || e > 127) begin
         res.range_error = 1'b1;
         return res;
      end
      mant = neg ? (41'd0 - mag[40:0]) : mag[40:0];
      res.word = {e[6:0], mant};
      return res;
   endfunction

   function automatic logic [DoubleWidth-1:0] make_double(input bit s, input int unsigned ex,
                                                         input logic [51:0] f);
      return {s, ex[10:0], f};
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stimulus: a directed set of edge cases, then random doubles.
   initial begin
      logic [51:0] f;
      int unsigned ex;
      reset = 1'b1;
      stimulus_done = 1'b0;
      hold_off = 1'b0;
      pending_values.push_back(64'h0000_0000_0000_0000);
      pending_values.push_back(64'h8000_0000_0000_0000);
      pending_values.push_back(64'h0000_0000_0000_0001);
      pending_values.push_back(64'h800F_FFFF_FFFF_FFFF);
      pending_values.push_back(64'h7FF0_0000_0000_0000);
      pending_values.push_back(64'hFFF0_0000_0000_0000);
      pending_values.push_back(64'h7FF8_0000_0000_0001);
      pending_values.push_back(64'h3FE0_0000_0000_0000);
      pending_values.push_back(64'hBFE0_0000_0000_0000);
      pending_values.push_back(64'h3FEF_FFFF_FFFF_FFFF);
      pending_values.push_back(64'hBFEF_FFFF_FFFF_FFFF);
      pending_values.push_back(64'h3FF0_0000_0000_0000);
      pending_values.push_back(64'hBFF0_0000_0000_0000);
      pending_values.push_back(make_double(0, 958, 52'h0));
      pending_values.push_back(make_double(1, 958, 52'h0));
      pending_values.push_back(make_double(0, 959, 52'h0));
      pending_values.push_back(make_double(0, 1085, 52'hF_FFFF_FFFF_FFFF));
      pending_values.push_back(make_double(1, 1085, 52'hF_FFFF_FFFF_FFFF));
      pending_values.push_back(make_double(0, 1085, 52'h0));
      pending_values.push_back(make_double(0, 1086, 52'h0));
      pending_values.push_back(make_double(0, 1022, 52'h0_0000_0000_1000));
      pending_values.push_back(make_double(1, 1022, 52'h0_0000_0000_1000));
      pending_values.push_back(make_double(0, 1022, 52'h0_0000_0000_0FFF));
      pending_values.push_back(make_double(1, 959, 52'h0));
      pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 800; i++) begin
         f = 52'({$urandom, $urandom});
         case ($urandom_range(9))
            0: ex = $urandom_range(2047);
            1: ex = $urandom_range(1) ? $urandom_range(960, 950) : $urandom_range(1090, 1080);
            2: begin
               ex = $urandom_range(1085, 958);
               f[11:0] = $urandom_range(1) ? 12'hFFF : 12'h000;
               f[51:12] = $urandom_range(1) ? '1 : '0;
            end
            default: ex = $urandom_range(1085, 958);
         endcase
         pending_values.push_back(make_double($urandom_range(1), ex, f));
         // Once, let the converter drain completely before continuing.
         if (i == 400) begin
            wait (pending_values.size() == 1);
            hold_off = 1'b1;
            wait (expected_words.size() == 0 && pending_values.size() == 1);
            @(negedge clock);
            hold_off = 1'b0;
         end
      end
      stimulus_done = 1'b1;
   end

   // Driver: bursts of transactions separated by random gaps; a presented
   // transaction stays until it has been accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_value_bits <= '0;
         burst_left     <= 0;
         gap_left       <= 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0 || hold_off || pending_values.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            req_valid      <= 1'b1;
            req_value_bits <= pending_values[0];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(20, 1);
               gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Response side stalls on its own random pattern, with quiet stretches.
   always @(negedge clock) begin
      rsp_stall <= (cycle_count % 512 < 128) ? 1'b0 : ($urandom_range(3) == 0);
   end

   // Monitor: record accepted requests and check accepted responses.
   always @(posedge clock) begin
      float_result_type got;
      float_result_type want;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_words.push_back(convert_double(req_value_bits));
         void'(pending_values.pop_front());
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_float_word, rsp_range_error};
         if (expected_words.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("Unexpected transaction: word %h error %b", got.word, got.range_error);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("Mismatch: expected word %h error %b, got word %h error %b",
                           want.word, want.range_error, got.word, got.range_error);
            end
         end
      end
   end

   // End of run and timeout.
   initial begin
      wait (stimulus_done && pending_values.size() == 0 && expected_words.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("DONE: errors detected");
      $finish;
   end
endmodule
